// ===== rtl/css_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera shutter sequencer package
// Shared item types, phase and mode codes, and reset constants.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int unsigned TicksWidth = 32;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned DelayWidth = 16;

  localparam logic [DelayWidth-1:0] DelayMsReset = 16'd100;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_EXPOSE = 2'd1,
    PH_WAIT   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_EXP_TICK = 2'd1,
    MODE_MS_TICK  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [TicksWidth-1:0] exposure_ticks;
    logic [CountWidth-1:0] image_count;
  } in_item_t;

  typedef struct packed {
    logic                  shutter_open;
    logic [1:0]            phase;
    logic [CountWidth-1:0] images_left;
    logic                  start_taken;
  } out_item_t;

endpackage

// ===== rtl/css_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera shutter sequencer input stage
// Registers one incoming item and releases it when the core takes it.
// ----------------------------------------------------------------------------
module css_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  css_pkg::in_item_t in_item_i,
  output logic              item_valid_o,
  output css_pkg::in_item_t item_o,
  input  logic              item_pop_i
);

  logic              valid_q;
  logic              valid_d;
  css_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || item_pop_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !item_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/css_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera shutter sequencer core
// Holds the burst state, applies one item per cycle while the output is not stalled and registers the result.
// ----------------------------------------------------------------------------
module css_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [css_pkg::DelayWidth-1:0]      cfg_data_i,
  input  logic                                item_valid_i,
  input  css_pkg::in_item_t                   item_i,
  output logic                                item_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output css_pkg::out_item_t                  out_item_o
);

  localparam int unsigned TW = css_pkg::TicksWidth;
  localparam int unsigned CW = css_pkg::CountWidth;
  localparam int unsigned DW = css_pkg::DelayWidth;

  logic [DW-1:0]      delay_q;
  css_pkg::phase_e    phase_q, phase_d;
  logic [TW-1:0]      exp_count_q, exp_count_d;
  logic [TW-1:0]      exp_len_q, exp_len_d;
  logic [CW-1:0]      images_q, images_d;
  logic [DW-1:0]      wait_q, wait_d;
  logic               taken;
  logic               out_valid_q;
  css_pkg::out_item_t out_item_q;
  logic               advance;
  logic [TW-1:0]      exp_inc;
  logic [DW-1:0]      wait_inc;
  logic [CW-1:0]      images_dec;

  assign advance    = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = advance;

  assign exp_inc    = (exp_count_q == '1) ? exp_count_q : exp_count_q + 1'b1;
  assign wait_inc   = (wait_q == '1) ? wait_q : wait_q + 1'b1;
  assign images_dec = (images_q == '0) ? images_q : images_q - 1'b1;

  always_comb begin
    phase_d     = phase_q;
    exp_count_d = exp_count_q;
    exp_len_d   = exp_len_q;
    images_d    = images_q;
    wait_d      = wait_q;
    taken       = 1'b0;
    case (css_pkg::mode_e'(item_i.mode))
      css_pkg::MODE_START: begin
        if (phase_q == css_pkg::PH_IDLE && item_i.image_count != '0) begin
          exp_len_d   = (item_i.exposure_ticks == '0) ? TW'(1) : item_i.exposure_ticks;
          images_d    = item_i.image_count;
          exp_count_d = '0;
          phase_d     = css_pkg::PH_EXPOSE;
          taken       = 1'b1;
        end
      end
      css_pkg::MODE_EXP_TICK: begin
        if (phase_q == css_pkg::PH_EXPOSE) begin
          exp_count_d = exp_inc;
          if (exp_inc >= exp_len_q) begin
            images_d = images_dec;
            wait_d   = '0;
            if (delay_q == '0) begin
              if (images_dec != '0) begin
                exp_count_d = '0;
                phase_d     = css_pkg::PH_EXPOSE;
              end else begin
                phase_d = css_pkg::PH_IDLE;
              end
            end else begin
              phase_d = css_pkg::PH_WAIT;
            end
          end
        end
      end
      css_pkg::MODE_MS_TICK: begin
        if (phase_q == css_pkg::PH_WAIT) begin
          wait_d = wait_inc;
          if (wait_inc >= delay_q) begin
            if (images_q != '0) begin
              exp_count_d = '0;
              phase_d     = css_pkg::PH_EXPOSE;
            end else begin
              phase_d = css_pkg::PH_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= css_pkg::DelayMsReset;
      phase_q     <= css_pkg::PH_IDLE;
      exp_count_q <= '0;
      exp_len_q   <= '0;
      images_q    <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delay_q <= cfg_data_i;
      end
      if (advance) begin
        phase_q     <= phase_d;
        exp_count_q <= exp_count_d;
        exp_len_q   <= exp_len_d;
        images_q    <= images_d;
        wait_q      <= wait_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.shutter_open <= (phase_d == css_pkg::PH_EXPOSE);
      out_item_q.phase        <= phase_d;
      out_item_q.images_left  <= images_d;
      out_item_q.start_taken  <= taken;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/camera_shutter_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera shutter sequencer
// Burst exposure sequencer driven by start commands and timer tick items.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled and
// returns one result item for each, via the input register and then the result
// register. The rate is set by the single state update between the two, where
// the exposure and wait counters advance by one per tick item. The user must
// write the inter-image delay register through cfg_we_i and cfg_data_i only
// while no item is in flight, which the block does not enforce. The register resets to 100 ticks.
module camera_shutter_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  css_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output css_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [css_pkg::DelayWidth-1:0] cfg_data_i
);

  logic              item_valid;
  logic              item_pop;
  css_pkg::in_item_t item;

  css_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  css_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== tb/camera_shutter_sequencer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera shutter sequencer testbench
// Drives start commands and timer tick items into the sequencer. A scoreboard
// class tracks the burst state and the inter-image delay, predicts the status
// that each accepted item should produce, and checks the returned status items
// in order. The run covers directed corner cases, then random bursts under
// several delay settings and idle and stall profiles.
// ----------------------------------------------------------------------------
module camera_shutter_sequencer_unit_test;

  class shutter_scoreboard;
    css_pkg::phase_e    phase;
    logic [31:0]        exp_count;
    logic [31:0]        exp_len;
    logic [15:0]        imgs_left;
    logic [15:0]        wait_count;
    logic [15:0]        delay_ms;
    css_pkg::out_item_t expected_status[$];
    int                 errors;
    int                 checked;
    int                 bursts;

    function new();
      phase      = css_pkg::PH_IDLE;
      exp_count  = '0;
      exp_len    = '0;
      imgs_left  = '0;
      wait_count = '0;
      delay_ms   = css_pkg::DelayMsReset;
      errors     = 0;
      checked    = 0;
      bursts     = 0;
    endfunction

    function void set_delay(logic [15:0] value);
      delay_ms = value;
    endfunction

    function void next_exposure_or_idle();
      if (imgs_left != 16'd0) begin
        exp_count = '0;
        phase     = css_pkg::PH_EXPOSE;
      end else begin
        phase = css_pkg::PH_IDLE;
      end
    endfunction

    function void predict_step(css_pkg::in_item_t it);
      css_pkg::out_item_t want;
      logic               taken;
      taken = 1'b0;
      case (it.mode)
        css_pkg::MODE_START: begin
          if (phase == css_pkg::PH_IDLE && it.image_count != 16'd0) begin
            exp_len   = (it.exposure_ticks == 32'd0) ? 32'd1 : it.exposure_ticks;
            imgs_left = it.image_count;
            exp_count = '0;
            phase     = css_pkg::PH_EXPOSE;
            taken     = 1'b1;
            bursts++;
          end
        end
        css_pkg::MODE_EXP_TICK: begin
          if (phase == css_pkg::PH_EXPOSE) begin
            if (exp_count != 32'hFFFF_FFFF) exp_count = exp_count + 32'd1;
            if (exp_count >= exp_len) begin
              if (imgs_left != 16'd0) imgs_left = imgs_left - 16'd1;
              wait_count = '0;
              if (delay_ms == 16'd0) next_exposure_or_idle();
              else phase = css_pkg::PH_WAIT;
            end
          end
        end
        css_pkg::MODE_MS_TICK: begin
          if (phase == css_pkg::PH_WAIT) begin
            if (wait_count != 16'hFFFF) wait_count = wait_count + 16'd1;
            if (wait_count >= delay_ms) next_exposure_or_idle();
          end
        end
        default: begin
        end
      endcase
      want.shutter_open = (phase == css_pkg::PH_EXPOSE);
      want.phase        = phase;
      want.images_left  = imgs_left;
      want.start_taken  = taken;
      expected_status.push_back(want);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(css_pkg::out_item_t got);
      css_pkg::out_item_t want;
      if (expected_status.size() == 0) begin
        report_mismatch("status item arrived with none expected");
      end else begin
        want = expected_status.pop_front();
        checked++;
        if (got.shutter_open !== want.shutter_open)
          report_mismatch($sformatf("shutter_open got %0b want %0b",
                                    got.shutter_open, want.shutter_open));
        if (got.phase !== want.phase)
          report_mismatch($sformatf("phase got %0d want %0d", got.phase, want.phase));
        if (got.images_left !== want.images_left)
          report_mismatch($sformatf("images_left got %0d want %0d",
                                    got.images_left, want.images_left));
        if (got.start_taken !== want.start_taken)
          report_mismatch($sformatf("start_taken got %0b want %0b",
                                    got.start_taken, want.start_taken));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  css_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  css_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_data = '0;

  shutter_scoreboard board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int items_sent     = 0;

  camera_shutter_sequencer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) board.check_result(out_item);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic css_pkg::in_item_t make_item(css_pkg::mode_e mode, logic [31:0] ticks,
                                                  logic [15:0] count);
    css_pkg::in_item_t it;
    it.mode           = mode;
    it.exposure_ticks = ticks;
    it.image_count    = count;
    return it;
  endfunction

  // Mostly items that move the burst along; the rest is random noise. Starts
  // that could be taken keep the burst short so that it always finishes.
  function automatic css_pkg::in_item_t pick_item();
    css_pkg::in_item_t it;
    it.mode           = 2'($urandom_range(3));
    it.exposure_ticks = $urandom();
    it.image_count    = 16'($urandom());
    if ($urandom_range(99) < 85) begin
      case (board.phase)
        css_pkg::PH_IDLE:   it.mode = css_pkg::MODE_START;
        css_pkg::PH_EXPOSE: it.mode = css_pkg::MODE_EXP_TICK;
        default:            it.mode = css_pkg::MODE_MS_TICK;
      endcase
    end
    if (it.mode == css_pkg::MODE_START && board.phase == css_pkg::PH_IDLE) begin
      it.exposure_ticks = ($urandom_range(9) < 7) ? $urandom_range(6) : $urandom_range(40);
      it.image_count    = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    end
    return it;
  endfunction

  task automatic send_item(input css_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    board.predict_step(it);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [15:0] value);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_delay(value);
  endtask

  task automatic run_random(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      send_item(pick_item());
      sent++;
    end
  endtask

  initial begin
    logic [15:0]       delays[6];
    int                send_pcts[6];
    int                recv_pcts[6];
    int                targets[6];
    css_pkg::in_item_t it;
    delays    = '{16'd0, 16'd3, 16'd1, 16'hFFFF, 16'd2, 16'd5};
    send_pcts = '{0, 61, 0, 36, 0, 36};
    recv_pcts = '{0, 0, 61, 36, 0, 36};
    targets   = '{200, 200, 200, 100, 150, 250};
    board = new();
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(css_pkg::mode_e'(2'd3), 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_item(css_pkg::MODE_MS_TICK, 32'd0, 16'd0));
    send_item(make_item(css_pkg::MODE_EXP_TICK, 32'd0, 16'd0));
    send_item(make_item(css_pkg::MODE_START, 32'd5, 16'd0));
    send_item(make_item(css_pkg::MODE_START, 32'd0, 16'd2));
    send_item(make_item(css_pkg::MODE_START, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_item(css_pkg::MODE_MS_TICK, 32'd0, 16'd0));
    send_item(make_item(css_pkg::MODE_EXP_TICK, 32'd0, 16'd0));
    send_item(make_item(css_pkg::MODE_EXP_TICK, 32'd0, 16'd0));
    send_item(make_item(css_pkg::MODE_START, 32'd1, 16'd1));
    repeat (3) send_item(make_item(css_pkg::MODE_MS_TICK, 32'd0, 16'd0));
    write_delay(16'd2);
    send_item(make_item(css_pkg::MODE_MS_TICK, 32'd0, 16'd0));
    send_item(make_item(css_pkg::MODE_EXP_TICK, 32'd0, 16'd0));
    repeat (2) send_item(make_item(css_pkg::MODE_MS_TICK, 32'd0, 16'd0));
    write_delay(16'd0);
    send_item(make_item(css_pkg::MODE_START, 32'd2, 16'd1));
    repeat (2) send_item(make_item(css_pkg::MODE_EXP_TICK, 32'd0, 16'd0));
    send_item(make_item(css_pkg::mode_e'(2'd3), 32'd0, 16'd0));

    for (int p = 0; p < 6; p++) begin
      write_delay(delays[p]);
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 2) hold_req = 1'b1;
      if (p == 4) begin
        run_random(targets[p] / 2);
        drain_results();
        run_random(targets[p] / 2);
      end else begin
        run_random(targets[p]);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (board.phase != css_pkg::PH_IDLE) begin
      it = make_item((board.phase == css_pkg::PH_EXPOSE) ? css_pkg::MODE_EXP_TICK
                                                         : css_pkg::MODE_MS_TICK,
                     32'd0, 16'd0);
      send_item(it);
    end
    send_item(make_item(css_pkg::MODE_START, 32'hFFFF_FFFF, 16'hFFFF));
    repeat (3) send_item(make_item(css_pkg::MODE_EXP_TICK, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_item(css_pkg::MODE_START, 32'd0, 16'd1));

    drain_results();
    repeat (10) @(posedge clk_i);
    if (board.expected_status.size() != 0)
      board.report_mismatch($sformatf("%0d status items never arrived",
                                      board.expected_status.size()));
    $display("Sent %0d items and checked %0d status items over %0d bursts.",
             items_sent, board.checked, board.bursts);
    $display("Delays from 0 to 65535 ms ticks ran under four idle and stall profiles.");
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
